[rtl/core/assert_macros.svh]
// assertion helpers for the cache lookup checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// generic clocked assertion with synchronous active-low reset
`define SALWC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// same, on the block's own clock and reset
`define SALWC_CHECK(lbl, prop, msg) `SALWC_ASSERT(lbl, i_clk, i_rst_n, prop, msg)

`endif

[rtl/core/salwc_pkg.sv]
package salwc_pkg;

    // field widths
    localparam int ADDR_BITS  = 32;
    localparam int STAMP_W    = 32;
    localparam int TAG_W      = 32;
    localparam int SET_OUT_W  = 8;
    localparam int OFF_W      = 12;
    localparam int WAY_OUT_W  = 3;
    localparam int CFG_W      = 4;
    localparam int CFG_IDX_W  = 2;

    // geometry limits and defaults
    localparam int MAX_BLOCK_LOG2 = 12;
    localparam int DEF_MAX_SETS   = 256;
    localparam int DEF_MAX_WAYS   = 8;

    // register reset values
    localparam logic [CFG_W-1:0] RST_BLOCK_LOG2 = 4'd5;
    localparam logic [CFG_W-1:0] RST_SET_LOG2   = 4'd4;
    localparam logic [CFG_W-1:0] RST_WAYS       = 4'd4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_BLOCK_LOG2 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SET_LOG2   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WAYS       = 2'd2;

    typedef enum logic [1:0] {
        OUT_HIT        = 2'd0,
        OUT_CLEAN_MISS = 2'd1,
        OUT_DIRTY_MISS = 2'd2
    } t_outcome;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } t_state;

    typedef struct packed {
        logic                 mode;
        logic [ADDR_BITS-1:0] address;
        logic [STAMP_W-1:0]   stamp;
    } t_in;

    typedef struct packed {
        t_outcome             outcome;
        logic [TAG_W-1:0]     line_tag;
        logic [SET_OUT_W-1:0] set_index;
        logic [OFF_W-1:0]     byte_offset;
        logic [WAY_OUT_W-1:0] way;
        logic                 was_valid;
        logic                 was_dirty;
        logic [STAMP_W-1:0]   previous_stamp;
    } t_out;

    // one way of a set as held in the tag memory
    typedef struct packed {
        logic               valid;
        logic               dirty;
        logic [TAG_W-1:0]   tag;
        logic [STAMP_W-1:0] stamp;
    } t_line;

endpackage

[rtl/core/set_assoc_lru_writeback_cache_lookup.sv]
// timing: the row read and the request are registered, then the result is loaded
//   into the output register, held back while a waiting result is stalled; a new
//   access is taken only once the last one is written back, set by the single tag
//   memory (row read first, then compare and row write-back)
// reset: registers go to block 32 bytes, 16 sets, 4 ways; a clearing pass then
//   zeroes all MAX_SETS rows (256 by default) of the tag memory, input stalled
module set_assoc_lru_writeback_cache_lookup #(
    parameter int MAX_SETS = salwc_pkg::DEF_MAX_SETS,
    parameter int MAX_WAYS = salwc_pkg::DEF_MAX_WAYS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [salwc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [salwc_pkg::CFG_W-1:0]         i_cfg_wdata,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  salwc_pkg::t_in                      i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output salwc_pkg::t_out                     o_out_data
);

    localparam int CW           = salwc_pkg::CFG_W;
    localparam int AW           = salwc_pkg::ADDR_BITS;
    localparam int SET_W        = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int SET_LOG2_MAX = $clog2(MAX_SETS + 1) - 1;
    localparam int WAY_W        = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WCNT_W       = $clog2(MAX_WAYS + 1);

    typedef salwc_pkg::t_line [MAX_WAYS-1:0] t_row;

    // configuration registers
    logic [CW-1:0] r_block_log2;
    logic [CW-1:0] r_set_log2;
    logic [CW-1:0] r_ways;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_log2 <= salwc_pkg::RST_BLOCK_LOG2;
            r_set_log2   <= salwc_pkg::RST_SET_LOG2;
            r_ways       <= salwc_pkg::RST_WAYS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                salwc_pkg::CFG_IDX_BLOCK_LOG2: r_block_log2 <= i_cfg_wdata;
                salwc_pkg::CFG_IDX_SET_LOG2:   r_set_log2   <= i_cfg_wdata;
                salwc_pkg::CFG_IDX_WAYS:       r_ways       <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // clamped geometry
    logic [CW-1:0]     eff_b;
    logic [CW-1:0]     eff_s;
    logic [CW:0]       ways_ext;
    logic [WCNT_W-1:0] eff_ways;

    assign eff_b = (r_block_log2 > CW'(salwc_pkg::MAX_BLOCK_LOG2))
                 ? CW'(salwc_pkg::MAX_BLOCK_LOG2) : r_block_log2;
    assign eff_s = (r_set_log2 > CW'(SET_LOG2_MAX)) ? CW'(SET_LOG2_MAX) : r_set_log2;
    assign ways_ext = {1'b0, r_ways};

    always_comb begin
        if (ways_ext == '0) begin
            eff_ways = WCNT_W'(1);
        end else if (ways_ext > (CW+1)'(MAX_WAYS)) begin
            eff_ways = WCNT_W'(MAX_WAYS);
        end else begin
            eff_ways = WCNT_W'(ways_ext);
        end
    end

    // address split of the incoming access
    logic [AW-1:0]                   addr_above;
    logic [AW-1:0]                   off_mask;
    logic [AW-1:0]                   set_mask;
    logic [SET_W-1:0]                split_set;
    logic [salwc_pkg::TAG_W-1:0]     split_tag;
    logic [salwc_pkg::OFF_W-1:0]     split_off;

    assign addr_above = i_in_data.address >> eff_b;
    assign off_mask   = (AW'(1) << eff_b) - AW'(1);
    assign set_mask   = (AW'(1) << eff_s) - AW'(1);
    assign split_off  = salwc_pkg::OFF_W'(i_in_data.address & off_mask);
    assign split_set  = SET_W'(addr_above & set_mask);
    assign split_tag  = salwc_pkg::TAG_W'(addr_above >> eff_s);

    // control
    salwc_pkg::t_state r_state;
    salwc_pkg::t_state n_state;
    logic [SET_W-1:0]  r_clr_idx;
    logic              r_out_valid;
    logic              out_free;
    logic              in_stall;
    logic              mem_re;
    logic              mem_we;
    logic              out_load;
    logic              clr_last;

    assign out_free = !r_out_valid || !i_out_stall;
    assign clr_last = (r_clr_idx == SET_W'(MAX_SETS - 1));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            salwc_pkg::ST_CLEAR:  if (clr_last) n_state = salwc_pkg::ST_IDLE;
            salwc_pkg::ST_IDLE:   if (i_in_valid) n_state = salwc_pkg::ST_LOOKUP;
            salwc_pkg::ST_LOOKUP: if (out_free) n_state = salwc_pkg::ST_IDLE;
            default:              n_state = salwc_pkg::ST_CLEAR;
        endcase
    end

    // state outputs
    always_comb begin
        in_stall = 1'b1;
        mem_re   = 1'b0;
        mem_we   = 1'b0;
        out_load = 1'b0;
        unique case (r_state)
            salwc_pkg::ST_CLEAR: begin
                mem_we = 1'b1;
            end
            salwc_pkg::ST_IDLE: begin
                in_stall = 1'b0;
                mem_re   = i_in_valid;
            end
            salwc_pkg::ST_LOOKUP: begin
                mem_we   = out_free;
                out_load = out_free;
            end
            default: ;
        endcase
    end

    assign o_in_stall = in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= salwc_pkg::ST_CLEAR;
            r_clr_idx <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == salwc_pkg::ST_CLEAR) begin
                r_clr_idx <= r_clr_idx + SET_W'(1);
            end
        end
    end

    // request held across the lookup
    logic                            r_req_write;
    logic [SET_W-1:0]                r_req_set;
    logic [salwc_pkg::TAG_W-1:0]     r_req_tag;
    logic [salwc_pkg::OFF_W-1:0]     r_req_off;
    logic [salwc_pkg::STAMP_W-1:0]   r_req_stamp;

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_req_write <= i_in_data.mode;
            r_req_set   <= split_set;
            r_req_tag   <= split_tag;
            r_req_off   <= split_off;
            r_req_stamp <= i_in_data.stamp;
        end
    end

    // tag memory, one row per set
    t_row             mem [MAX_SETS];
    t_row             r_rdata;
    t_row             new_row;
    t_row             mem_wdata;
    logic [SET_W-1:0] mem_waddr;

    assign mem_waddr = (r_state == salwc_pkg::ST_CLEAR) ? r_clr_idx : r_req_set;
    assign mem_wdata = (r_state == salwc_pkg::ST_CLEAR) ? '0 : new_row;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= mem[split_set];
        end
    end

    // hit search, first free way and lru victim over the row read
    logic [MAX_WAYS-1:0] way_en;
    logic [MAX_WAYS-1:0] hit_vec;
    logic [MAX_WAYS-1:0] inv_vec;
    logic [MAX_WAYS-1:0] lru_vec;
    logic [WAY_W-1:0]    hit_idx;
    logic [WAY_W-1:0]    inv_idx;
    logic [WAY_W-1:0]    lru_idx;
    logic [WAY_W-1:0]    sel_way;
    logic                is_hit;
    salwc_pkg::t_line    sel_line;

    always_comb begin
        for (int i = 0; i < MAX_WAYS; i++) begin
            way_en[i]  = (WCNT_W'(i) < eff_ways);
            hit_vec[i] = way_en[i] && r_rdata[i].valid && (r_rdata[i].tag == r_req_tag);
            inv_vec[i] = way_en[i] && !r_rdata[i].valid;
            // oldest stamp, lower way wins a tie
            lru_vec[i] = way_en[i];
            for (int j = 0; j < MAX_WAYS; j++) begin
                if (j < i && way_en[j] && !(r_rdata[i].stamp < r_rdata[j].stamp)) begin
                    lru_vec[i] = 1'b0;
                end
                if (j > i && way_en[j] && !(r_rdata[i].stamp <= r_rdata[j].stamp)) begin
                    lru_vec[i] = 1'b0;
                end
            end
        end
    end

    // lowest-way priority encoders
    always_comb begin
        hit_idx = '0;
        inv_idx = '0;
        lru_idx = '0;
        for (int i = MAX_WAYS - 1; i >= 0; i--) begin
            if (hit_vec[i]) hit_idx = WAY_W'(i);
            if (inv_vec[i]) inv_idx = WAY_W'(i);
            if (lru_vec[i]) lru_idx = WAY_W'(i);
        end
    end

    assign is_hit = |hit_vec;

    always_comb begin
        if (is_hit) begin
            sel_way = hit_idx;
        end else if (|inv_vec) begin
            sel_way = inv_idx;
        end else begin
            sel_way = lru_idx;
        end
    end

    assign sel_line = r_rdata[sel_way];

    // row write-back: refresh on hit, refill on miss
    always_comb begin
        new_row = r_rdata;
        if (is_hit) begin
            new_row[sel_way].stamp = r_req_stamp;
            new_row[sel_way].dirty = sel_line.dirty | r_req_write;
        end else begin
            new_row[sel_way].valid = 1'b1;
            new_row[sel_way].dirty = r_req_write;
            new_row[sel_way].tag   = r_req_tag;
            new_row[sel_way].stamp = r_req_stamp;
        end
    end

    // result
    salwc_pkg::t_out res;
    salwc_pkg::t_out r_out;

    always_comb begin
        if (is_hit) begin
            res.outcome = salwc_pkg::OUT_HIT;
        end else if (sel_line.valid && sel_line.dirty) begin
            res.outcome = salwc_pkg::OUT_DIRTY_MISS;
        end else begin
            res.outcome = salwc_pkg::OUT_CLEAN_MISS;
        end
        res.line_tag       = r_req_tag;
        res.set_index      = salwc_pkg::SET_OUT_W'(r_req_set);
        res.byte_offset    = r_req_off;
        res.way            = salwc_pkg::WAY_OUT_W'(sel_way);
        res.was_valid      = sel_line.valid;
        res.was_dirty      = sel_line.dirty;
        res.previous_stamp = is_hit ? sel_line.stamp : '0;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

[rtl/core/salwc_chk.sv]
`include "assert_macros.svh"

module salwc_chk (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_in_valid,
    input logic            o_in_stall,
    input salwc_pkg::t_in  i_in_data,
    input logic            o_out_valid,
    input logic            i_out_stall,
    input salwc_pkg::t_out o_out_data
);

    // a waiting result holds until transferred
    `SALWC_CHECK(a_out_hold, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data), "result changed while stalled")

    // an accepted access blocks the input during its lookup
    `SALWC_CHECK(a_one_in_flight, i_in_valid && !o_in_stall |=> o_in_stall, "input not stalled during lookup")

    // a new result only comes out of a lookup
    `SALWC_CHECK(a_result_from_lookup, $rose(o_out_valid) |-> $past(o_in_stall), "result without lookup")

    // clearing pass keeps the input stalled right after reset
    `SALWC_CHECK(a_clear_after_reset, !$past(i_rst_n) |-> o_in_stall, "input open during clearing pass")

endmodule

bind set_assoc_lru_writeback_cache_lookup salwc_chk u_salwc_chk (.*);

[dv/set_assoc_lru_writeback_cache_lookup_test.sv]
module set_assoc_lru_writeback_cache_lookup_test;
    import salwc_pkg::*;

    localparam int SETS        = DEF_MAX_SETS;
    localparam int WAYS        = DEF_MAX_WAYS;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;

    // index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_wdata;
    logic                 i_in_valid;
    logic                 o_in_stall;
    t_in                  i_in_data;
    logic                 o_out_valid;
    logic                 i_out_stall;
    t_out                 o_out_data;

    set_assoc_lru_writeback_cache_lookup uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // shadow copy of the geometry registers and the tag store
    logic [CFG_W-1:0]   blk_log2_reg = RST_BLOCK_LOG2;
    logic [CFG_W-1:0]   set_log2_reg = RST_SET_LOG2;
    logic [CFG_W-1:0]   ways_reg     = RST_WAYS;
    bit                 way_valid [SETS*WAYS];
    bit                 way_dirty [SETS*WAYS];
    logic [TAG_W-1:0]   way_tag   [SETS*WAYS];
    logic [STAMP_W-1:0] way_stamp [SETS*WAYS];

    t_out               pending_lookups[$];
    int unsigned        mismatches  = 0;
    int unsigned        cycle_count = 0;
    int                 send_gap_pct;
    int                 stall_pct;
    bit                 hold_request;
    logic [STAMP_W-1:0] stamp_ctr;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    // run limit
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("status: fail");
        $finish;
    end

    function automatic bit roll(int pct);
        return $urandom_range(99, 0) < pct;
    endfunction

    // effective geometry after clamping the register values
    function automatic int unsigned offset_bits();
        return (blk_log2_reg > MAX_BLOCK_LOG2) ? MAX_BLOCK_LOG2 : blk_log2_reg;
    endfunction

    function automatic int unsigned index_bits();
        int unsigned s;
        s = set_log2_reg;
        while (s > 0 && (1 << s) > SETS) s--;
        return s;
    endfunction

    function automatic int unsigned ways_searched();
        int unsigned n;
        n = (ways_reg == 0) ? 1 : ways_reg;
        return (n > WAYS) ? WAYS : n;
    endfunction

    // lookup, lru victim choice and tag store update for one access
    function automatic t_out predict_lookup(t_in acc);
        t_out               res;
        int unsigned        b, s, n, set_no, base, sel;
        logic [ADDR_BITS-1:0] above;
        logic [STAMP_W-1:0] oldest;
        bit                 hit, found;
        b = offset_bits();
        s = index_bits();
        n = ways_searched();
        res = '0;
        above = acc.address >> b;
        res.byte_offset = OFF_W'(acc.address & ((32'd1 << b) - 32'd1));
        set_no = above & ((32'd1 << s) - 32'd1);
        res.set_index = SET_OUT_W'(set_no);
        res.line_tag = above >> s;
        base = set_no * WAYS;
        hit = 1'b0;
        sel = 0;
        for (int i = 0; i < n; i++) begin
            if (!hit && way_valid[base+i] && way_tag[base+i] == res.line_tag) begin
                hit = 1'b1;
                sel = i;
            end
        end
        if (hit) begin
            res.outcome = OUT_HIT;
            res.was_valid = 1'b1;
            res.was_dirty = way_dirty[base+sel];
            res.previous_stamp = way_stamp[base+sel];
            way_stamp[base+sel] = acc.stamp;
            if (acc.mode) way_dirty[base+sel] = 1'b1;
        end else begin
            // first invalid way, else oldest stamp with the lowest way on a tie
            found = 1'b0;
            oldest = '0;
            for (int i = 0; i < n; i++) begin
                if (!found) begin
                    if (!way_valid[base+i]) begin
                        sel = i;
                        found = 1'b1;
                    end else if (i == 0 || way_stamp[base+i] < oldest) begin
                        oldest = way_stamp[base+i];
                        sel = i;
                    end
                end
            end
            res.was_valid = way_valid[base+sel];
            res.was_dirty = way_dirty[base+sel];
            res.outcome = (way_valid[base+sel] && way_dirty[base+sel]) ?
                          OUT_DIRTY_MISS : OUT_CLEAN_MISS;
            way_valid[base+sel] = 1'b1;
            way_dirty[base+sel] = acc.mode;
            way_tag[base+sel]   = res.line_tag;
            way_stamp[base+sel] = acc.stamp;
        end
        res.way = WAY_OUT_W'(sel);
        return res;
    endfunction

    function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    function automatic void check_result(t_out got);
        t_out want;
        if (pending_lookups.size() == 0) begin
            $display("%0t: result with none expected, expected nothing, actual 0x%0h",
                     $time, got);
            mismatches++;
            return;
        end
        want = pending_lookups.pop_front();
        compare_field("outcome", want.outcome, got.outcome);
        compare_field("line_tag", want.line_tag, got.line_tag);
        compare_field("set_index", want.set_index, got.set_index);
        compare_field("byte_offset", want.byte_offset, got.byte_offset);
        compare_field("way", want.way, got.way);
        compare_field("was_valid", want.was_valid, got.was_valid);
        compare_field("was_dirty", want.was_dirty, got.was_dirty);
        compare_field("previous_stamp", want.previous_stamp, got.previous_stamp);
    endfunction

    // watch both channels and the register port at each edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_IDX_BLOCK_LOG2: blk_log2_reg = i_cfg_wdata;
                    CFG_IDX_SET_LOG2:   set_log2_reg = i_cfg_wdata;
                    CFG_IDX_WAYS:       ways_reg     = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (o_out_valid && !i_out_stall) check_result(o_out_data);
            if (i_in_valid && !o_in_stall) pending_lookups.push_back(predict_lookup(i_in_data));
        end
    end

    // result side: random stalls, or a long hold-off on request
    initial begin
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                i_out_stall <= 1'b1;
                for (int n = 0; n < HOLD_CYCLES; n++) @(posedge i_clk);
            end
            i_out_stall <= roll(stall_pct);
        end
    end

    // offer one access and wait for its transfer
    task automatic send_access(input logic mode, input logic [31:0] addr,
                               input logic [31:0] stamp);
        t_in acc;
        acc.mode = mode;
        acc.address = addr;
        acc.stamp = stamp;
        if (roll(send_gap_pct)) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while (roll(send_gap_pct));
        end
        i_in_valid <= 1'b1;
        i_in_data <= acc;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // stop offering and wait until every lookup has come back
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_lookups.size() != 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // mostly rising stamps with ties, some fully random
    function automatic logic [31:0] next_stamp();
        if (roll(20)) return $urandom();
        stamp_ctr += $urandom_range(2, 0);
        return stamp_ctr;
    endfunction

    // small tag and set pool so that hits and evictions are common
    task automatic random_accesses(input int count);
        int unsigned b, s;
        logic [31:0] addr;
        repeat (count) begin
            b = offset_bits();
            s = index_bits();
            if (roll(15)) begin
                addr = $urandom();
            end else begin
                addr = (32'($urandom_range(7, 0)) << (b + s))
                     | ((32'($urandom_range(3, 0)) & ((32'd1 << s) - 32'd1)) << b)
                     | ($urandom() & ((32'd1 << b) - 32'd1));
            end
            send_access(1'($urandom_range(1, 0)), addr, next_stamp());
        end
    endtask

    // reset geometry: hits, dirty hits, address extremes, lru ties and eviction
    task automatic test_default_geometry();
        send_gap_pct = 0;
        stall_pct = 0;
        send_access(1'b0, 32'h0000_0000, 32'h0000_0000);
        send_access(1'b1, 32'h0000_001F, 32'hFFFF_FFFF);
        send_access(1'b0, 32'h0000_0010, 32'h0000_0005);
        send_access(1'b1, 32'hFFFF_FFFF, 32'h0000_0001);
        send_access(1'b0, 32'hFFFF_FFE0, 32'h0000_0002);
        // fill the rest of set 0 with equal stamps
        send_access(1'b1, 32'h0000_0200, 32'h0000_0007);
        send_access(1'b0, 32'h0000_0400, 32'h0000_0007);
        send_access(1'b1, 32'h0000_0600, 32'h0000_0007);
        // evictions: oldest first, then lowest way among ties
        send_access(1'b0, 32'h0000_0800, 32'h0000_0009);
        send_access(1'b0, 32'h0000_0A00, 32'h0000_0009);
        send_access(1'b0, 32'h0000_0C00, 32'h0000_0009);
        send_access(1'b1, 32'h0000_0200, 32'h0000_0000);
    endtask

    // smallest and clamped geometries, zero ways and the spare index
    task automatic test_geometry_limits();
        write_reg(CFG_IDX_BLOCK_LOG2, 4'd0);
        write_reg(CFG_IDX_SET_LOG2, 4'd0);
        write_reg(CFG_IDX_WAYS, 4'd1);
        send_access(1'b1, 32'hFFFF_FFFF, next_stamp());
        send_access(1'b0, 32'hFFFF_FFFF, next_stamp());
        send_access(1'b0, 32'h0000_0000, next_stamp());
        write_reg(CFG_IDX_BLOCK_LOG2, 4'd15);
        write_reg(CFG_IDX_SET_LOG2, 4'd15);
        write_reg(CFG_IDX_WAYS, 4'd15);
        send_access(1'b0, 32'hFFFF_FFFF, next_stamp());
        send_access(1'b1, 32'hFFFF_F000, next_stamp());
        send_access(1'b0, 32'h000F_FFFF, next_stamp());
        write_reg(CFG_IDX_WAYS, 4'd0);
        write_reg(CFG_IDX_SPARE, 4'd15);
        send_access(1'b0, 32'h1234_5678, next_stamp());
        send_access(1'b1, 32'h1234_5678, next_stamp());
    endtask

    // random traffic over random geometries, one idling pattern per phase
    task automatic test_random_traffic();
        int gap_by_phase [4] = '{0, 63, 0, 15};
        int stall_by_phase [4] = '{0, 0, 63, 15};
        for (int p = 0; p < 4; p++) begin
            for (int k = 0; k < 2; k++) begin
                write_reg(CFG_IDX_BLOCK_LOG2, CFG_W'($urandom_range(15, 0)));
                write_reg(CFG_IDX_SET_LOG2, CFG_W'($urandom_range(15, 0)));
                write_reg(CFG_IDX_WAYS, CFG_W'($urandom_range(15, 0)));
                send_gap_pct = gap_by_phase[p];
                stall_pct = stall_by_phase[p];
                random_accesses(40);
            end
        end
    endtask

    // long hold-off on the result side while accesses keep coming
    task automatic test_backpressure();
        write_reg(CFG_IDX_BLOCK_LOG2, RST_BLOCK_LOG2);
        write_reg(CFG_IDX_SET_LOG2, 4'd2);
        write_reg(CFG_IDX_WAYS, 4'd8);
        send_gap_pct = 0;
        stall_pct = 0;
        hold_request = 1'b1;
        random_accesses(40);
        stall_pct = 30;
        random_accesses(20);
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= CFG_IDX_BLOCK_LOG2;
        i_cfg_wdata <= '0;
        i_in_valid <= 1'b0;
        i_in_data <= '0;
        send_gap_pct = 0;
        stall_pct = 0;
        hold_request = 1'b0;
        stamp_ctr = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_default_geometry();
        test_geometry_limits();
        test_random_traffic();
        test_backpressure();
        drain();

        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/salwc_pkg.sv
rtl/core/set_assoc_lru_writeback_cache_lookup.sv
rtl/core/salwc_chk.sv
dv/set_assoc_lru_writeback_cache_lookup_test.sv
